>>> src/lbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, codes and helpers for the lsb-first bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int StoreBytesDefault = 4096;
   localparam int MaxWidth          = 32;

   localparam int OpcodeW   = 3;
   localparam int WidthW    = 6;
   localparam int DataW     = 32;
   localparam int PositionW = 16;
   localparam int StatusW   = 2;
   localparam int CapW      = 13;

   localparam logic [CapW-1:0] CapReset = 13'd4096;

   typedef enum logic [OpcodeW-1:0] {
      OP_PUSH      = 3'd0,
      OP_POP       = 3'd1,
      OP_CLEAR     = 3'd2,
      OP_SET_READ  = 3'd3,
      OP_SET_WRITE = 3'd4
   } opcode_type;

   typedef enum logic [StatusW-1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_ROOM    = 2'd1,
      STAT_PAST_WRITE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_XFER,
      S_FIN
   } state_type;

   // low n bits set, n up to 32
   function automatic logic [DataW-1:0] width_mask(input logic [WidthW-1:0] n);
      logic [DataW:0] m;
      m = ((DataW+1)'(1) << n) - (DataW+1)'(1);
      return m[DataW-1:0];
   endfunction

endpackage
`default_nettype wire

>>> src/lbp_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_req_if
// Request channel: operation, width, data and position with valid/ready.
// ----------------------------------------------------------------------------
interface lbp_req_if import lbp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OpcodeW-1:0]   opcode;
   logic [WidthW-1:0]    width;
   logic [DataW-1:0]     data;
   logic [PositionW-1:0] position;

   modport source (output valid, opcode, width, data, position, input ready);
   modport sink   (input valid, opcode, width, data, position, output ready);
endinterface
`default_nettype wire

>>> src/lbp_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_rsp_if
// Response channel: popped bits, status and both positions with valid/ready.
// ----------------------------------------------------------------------------
interface lbp_rsp_if import lbp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DataW-1:0]     read_data;
   logic [StatusW-1:0]   status;
   logic [PositionW-1:0] read_position;
   logic [PositionW-1:0] write_position;

   modport source (output valid, read_data, status, read_position, write_position,
                   input ready);
   modport sink   (input valid, read_data, status, read_position, write_position,
                   output ready);
endinterface
`default_nettype wire

>>> src/lbp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_ram
// Generic single-clock ram, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lbp_ram #(
   parameter  int Width = 8,
   parameter  int Depth = 16,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/lsb_first_bit_packer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_core
// Bit buffer over a byte store, packed lsb first, with push, pop, clear and
// pointer set operations.
// ----------------------------------------------------------------------------
// push/pop of w bits at bit offset o touches n = ceil((o+w)/8) bytes (n <= 5);
// the single byte read-merge-write unit handles them in turn; set, unused codes,
// zero width and dropped pushes skip it, clear sweeps the whole store, and no
// new request is taken until the response of the last one is registered.
// reset: pointers cleared, capacity 4096, then a sweep over all STORE_BYTES bytes
// zeroes the store with no request transfer taken; csr writes are live.
module lsb_first_bit_packer_core import lbp_pkg::*; #(
   parameter int STORE_BYTES = StoreBytesDefault
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_write_enable,
   input  wire logic [CapW-1:0] csr_write_data,
   lbp_req_if.sink              req_if,
   lbp_rsp_if.source            rsp_if
);

   localparam int CapBits = STORE_BYTES * 8;
   localparam int PW      = $clog2(CapBits + 1);
   localparam int XW      = ((PW > PositionW) ? PW : PositionW) + 1;
   localparam int BW      = XW - 3;
   localparam int AW      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int WinW    = DataW + 8;
   localparam logic [AW-1:0] ClrLast = AW'(STORE_BYTES - 1);

   state_type        state_ff,   state_in;
   logic [CapW-1:0]  cap_ff,     cap_in;
   logic [PW-1:0]    rd_ptr_ff,  rd_ptr_in;
   logic [PW-1:0]    wr_ptr_ff,  wr_ptr_in;
   opcode_type       op_ff,      op_in;
   logic [WidthW-1:0] wd_ff,     wd_in;
   status_type       status_ff,  status_in;
   logic [BW-1:0]    base_ff,    base_in;
   logic [2:0]       off_ff,     off_in;
   logic [2:0]       nbytes_ff,  nbytes_in;
   logic [WinW-1:0]  win_ff,     win_in;
   logic [2:0]       iss_ff,     iss_in;
   logic             pv_ff,      pv_in;
   logic [2:0]       pk_ff,      pk_in;
   logic [AW-1:0]    pa_ff,      pa_in;
   logic             pin_ff,     pin_in;
   logic [AW-1:0]    clr_ff,     clr_in;
   logic             clr_op_ff,  clr_op_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DataW-1:0] rsp_data_ff,  rsp_data_in;
   logic [StatusW-1:0] rsp_status_ff, rsp_status_in;
   logic [PositionW-1:0] rsp_rpos_ff, rsp_rpos_in;
   logic [PositionW-1:0] rsp_wpos_ff, rsp_wpos_in;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [7:0]       mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic [7:0]       mem_rdata;

   // effective capacity in bytes and bits
   logic [XW-1:0]    cap_raw, capb, cap_bits;
   logic [XW-1:0]    rp_x, wp_x, pos_x, start_x;
   logic [XW-1:0]    push_sum, pop_sum;
   opcode_type       req_op;
   logic [WidthW-1:0] weff;
   logic [WidthW-1:0] nb_sum;
   logic [2:0]       nb;
   logic [WinW-1:0]  push_win;
   logic [BW-1:0]    iss_idx;
   logic             iss_in_range;
   logic [7:0]       byte_rd;
   logic [7:0]       merged;
   logic [WinW-1:0]  win_shifted;
   logic [DataW-1:0] pop_val;

   assign cap_raw  = XW'(cap_ff);
   assign capb     = (cap_raw == '0) ? XW'(1) :
                     ((cap_raw > XW'(STORE_BYTES)) ? XW'(STORE_BYTES) : cap_raw);
   assign cap_bits = {capb[XW-4:0], 3'b000};

   assign rp_x     = XW'(rd_ptr_ff);
   assign wp_x     = XW'(wr_ptr_ff);
   assign pos_x    = XW'(req_if.position);
   assign req_op   = opcode_type'(req_if.opcode);
   assign weff     = (req_if.width > WidthW'(MaxWidth)) ? WidthW'(MaxWidth) : req_if.width;
   assign start_x  = (req_op == OP_POP) ? rp_x : wp_x;
   assign push_sum = wp_x + XW'(weff);
   assign pop_sum  = rp_x + XW'(weff);
   assign nb_sum   = WidthW'(start_x[2:0]) + weff + WidthW'(7);
   assign nb       = (weff == '0) ? 3'd0 : nb_sum[5:3];
   assign push_win = WinW'(req_if.data & width_mask(weff)) << start_x[2:0];

   assign iss_idx      = base_ff + BW'(iss_ff);
   assign iss_in_range = XW'(iss_idx) < capb;
   assign byte_rd      = pin_ff ? mem_rdata : 8'h00;
   assign merged       = mem_rdata | win_ff[{pk_ff, 3'b000} +: 8];
   assign win_shifted  = win_ff >> off_ff;
   assign pop_val      = win_shifted[DataW-1:0] & width_mask(wd_ff);

   assign req_if.ready          = (state_ff == S_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.read_data      = rsp_data_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.read_position  = rsp_rpos_ff;
   assign rsp_if.write_position = rsp_wpos_ff;

   lbp_ram #(
      .Width (8),
      .Depth (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      cap_in        = csr_write_enable ? csr_write_data : cap_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      op_in         = op_ff;
      wd_in         = wd_ff;
      status_in     = status_ff;
      base_in       = base_ff;
      off_in        = off_ff;
      nbytes_in     = nbytes_ff;
      win_in        = win_ff;
      iss_in        = iss_ff;
      pv_in         = pv_ff;
      pk_in         = pk_ff;
      pa_in         = pa_ff;
      pin_in        = pin_ff;
      clr_in        = clr_ff;
      clr_op_in     = clr_op_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rpos_in   = rsp_rpos_ff;
      rsp_wpos_in   = rsp_wpos_ff;
      mem_we        = 1'b0;
      mem_waddr     = pa_ff;
      mem_wdata     = merged;
      mem_raddr     = iss_idx[AW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'h00;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == ClrLast) begin
               clr_in   = '0;
               state_in = clr_op_ff ? S_FIN : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_if.valid) begin
               op_in     = req_op;
               wd_in     = weff;
               status_in = STAT_OK;
               base_in   = start_x[XW-1:3];
               off_in    = start_x[2:0];
               nbytes_in = 3'd0;
               win_in    = '0;
               iss_in    = 3'd0;
               pv_in     = 1'b0;
               state_in  = S_FIN;
               unique case (req_op)
                  OP_PUSH: begin
                     if (push_sum > cap_bits) begin
                        status_in = STAT_NO_ROOM;
                     end else begin
                        wr_ptr_in = push_sum[PW-1:0];
                        nbytes_in = nb;
                        win_in    = push_win;
                        if (nb != 3'd0) begin
                           state_in = S_XFER;
                        end
                     end
                  end
                  OP_POP: begin
                     if (pop_sum > wp_x) begin
                        status_in = STAT_PAST_WRITE;
                     end
                     rd_ptr_in = (pop_sum > cap_bits) ? cap_bits[PW-1:0] : pop_sum[PW-1:0];
                     nbytes_in = nb;
                     if (nb != 3'd0) begin
                        state_in = S_XFER;
                     end
                  end
                  OP_CLEAR: begin
                     rd_ptr_in = '0;
                     wr_ptr_in = '0;
                     clr_op_in = 1'b1;
                     clr_in    = '0;
                     state_in  = S_CLEAR;
                  end
                  OP_SET_READ: begin
                     rd_ptr_in = (pos_x > cap_bits) ? cap_bits[PW-1:0] : pos_x[PW-1:0];
                  end
                  OP_SET_WRITE: begin
                     wr_ptr_in = (pos_x > cap_bits) ? cap_bits[PW-1:0] : pos_x[PW-1:0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_XFER: begin
            // issue the next byte read while merging the byte read last cycle
            if (iss_ff != nbytes_ff) begin
               iss_in = iss_ff + 3'd1;
               pv_in  = 1'b1;
               pk_in  = iss_ff;
               pa_in  = iss_idx[AW-1:0];
               pin_in = iss_in_range;
            end else begin
               pv_in    = 1'b0;
               state_in = S_FIN;
            end
            if (pv_ff) begin
               if (op_ff == OP_PUSH) begin
                  mem_we = 1'b1;
               end else begin
                  win_in = win_ff | (WinW'(byte_rd) << {pk_ff, 3'b000});
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = (op_ff == OP_POP) ? pop_val : '0;
               rsp_status_in = status_ff;
               rsp_rpos_in   = rp_x[PositionW-1:0];
               rsp_wpos_in   = wp_x[PositionW-1:0];
               clr_op_in     = 1'b0;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cap_ff       <= CapReset;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         iss_ff       <= 3'd0;
         pv_ff        <= 1'b0;
         clr_ff       <= '0;
         clr_op_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         iss_ff       <= iss_in;
         pv_ff        <= pv_in;
         clr_ff       <= clr_in;
         clr_op_ff    <= clr_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      wd_ff         <= wd_in;
      status_ff     <= status_in;
      base_ff       <= base_in;
      off_ff        <= off_in;
      nbytes_ff     <= nbytes_in;
      win_ff        <= win_in;
      pk_ff         <= pk_in;
      pa_ff         <= pa_in;
      pin_ff        <= pin_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rpos_ff   <= rsp_rpos_in;
      rsp_wpos_ff   <= rsp_wpos_in;
   end

endmodule
`default_nettype wire

>>> verif/tb_lsb_first_bit_packer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_packer_core
// Self-checking bench for the lsb-first bit packer. A shadow copy of the byte
// store, both bit pointers and the capacity register predicts every response.
// A short directed run covers the width limits, the no-room and past-write
// cases, reads beyond capacity, pointer saturation, clear and the unused
// codes. Randomised traffic then runs under several capacity settings, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_lsb_first_bit_packer_core import lbp_pkg::*; ();

   localparam int IdleLimit   = 20000;
   localparam int SettleTicks = 10;
   localparam int NumPhases   = 7;

   localparam logic [OpcodeW-1:0] OpFirstUnused = 3'd5;
   localparam logic [OpcodeW-1:0] OpLastUnused  = 3'd7;

   typedef struct packed {
      logic [OpcodeW-1:0]   opcode;
      logic [WidthW-1:0]    width;
      logic [DataW-1:0]     data;
      logic [PositionW-1:0] position;
   } bit_op_type;

   typedef struct packed {
      logic [DataW-1:0]     read_data;
      status_type           status;
      logic [PositionW-1:0] read_position;
      logic [PositionW-1:0] write_position;
   } bit_result_type;

   logic            clock;
   logic            reset;
   logic            csr_write_enable;
   logic [CapW-1:0] csr_write_data;

   lbp_req_if req_bus ();
   lbp_rsp_if rsp_bus ();

   lsb_first_bit_packer_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus)
   );

   // shadow state
   logic [7:0]      shadow_store [StoreBytesDefault];
   int              shadow_rd_pos;
   int              shadow_wr_pos;
   logic [CapW-1:0] shadow_cap_bytes;

   bit_result_type pending_results [$];

   int  error_count;
   int  result_count;
   int  op_count [8];
   int  unused_count;
   int  no_room_count;
   int  past_write_count;
   int  cap_settings;
   int  idle_cycles;
   int  rsp_hold;
   bit  req_idle_on;
   bit  rsp_idle_on;
   bit  req_valid_high;

   always #5 clock = ~clock;

   function automatic int usable_bits();
      int c;
      c = int'(shadow_cap_bytes);
      if (c < 1) c = 1;
      if (c > StoreBytesDefault) c = StoreBytesDefault;
      return c * 8;
   endfunction

   function automatic bit_result_type predict_bit_buffer(input bit_op_type op);
      bit_result_type r;
      int             cap;
      int             w;
      int             p;
      cap = usable_bits();
      w = (op.width > WidthW'(MaxWidth)) ? MaxWidth : int'(op.width);
      r.read_data = '0;
      r.status    = STAT_OK;
      case (op.opcode)
         OP_PUSH: begin
            if (shadow_wr_pos + w > cap) begin
               r.status = STAT_NO_ROOM;
            end else begin
               for (int i = 0; i < w; i++) begin
                  p = shadow_wr_pos + i;
                  if (op.data[i]) shadow_store[p / 8][p % 8] = 1'b1;
               end
               shadow_wr_pos += w;
            end
         end
         OP_POP: begin
            if (shadow_rd_pos + w > shadow_wr_pos) r.status = STAT_PAST_WRITE;
            for (int i = 0; i < w; i++) begin
               p = shadow_rd_pos + i;
               // bits at or past capacity read as zero
               if (p < cap) r.read_data[i] = shadow_store[p / 8][p % 8];
            end
            shadow_rd_pos += w;
            if (shadow_rd_pos > cap) shadow_rd_pos = cap;
         end
         OP_CLEAR: begin
            foreach (shadow_store[i]) shadow_store[i] = '0;
            shadow_rd_pos = 0;
            shadow_wr_pos = 0;
         end
         OP_SET_READ: begin
            shadow_rd_pos = (int'(op.position) > cap) ? cap : int'(op.position);
         end
         OP_SET_WRITE: begin
            shadow_wr_pos = (int'(op.position) > cap) ? cap : int'(op.position);
         end
         default: ;
      endcase
      r.read_position  = PositionW'(shadow_rd_pos);
      r.write_position = PositionW'(shadow_wr_pos);
      return r;
   endfunction

   function automatic bit_op_type make_op(input logic [OpcodeW-1:0]   opcode,
                                          input logic [WidthW-1:0]    width,
                                          input logic [DataW-1:0]     data,
                                          input logic [PositionW-1:0] position);
      bit_op_type op;
      op.opcode   = opcode;
      op.width    = width;
      op.data     = data;
      op.position = position;
      return op;
   endfunction

   function automatic bit_op_type random_op();
      bit_op_type op;
      int         sel;
      int         wsel;
      int         cap;
      cap  = usable_bits();
      sel  = $urandom_range(0, 99);
      wsel = $urandom_range(0, 19);
      if (wsel == 0) op.width = '0;
      else if (wsel == 1) op.width = WidthW'($urandom_range(MaxWidth + 1, 63));
      else op.width = WidthW'($urandom_range(1, MaxWidth));
      op.data     = $urandom();
      op.position = ($urandom_range(0, 4) == 0) ? PositionW'($urandom())
                                                : PositionW'($urandom_range(0, cap));
      if (sel < 40) begin
         op.opcode = OP_PUSH;
      end else if (sel < 75) begin
         op.opcode = OP_POP;
      end else if (sel < 84) begin
         op.opcode = OP_SET_READ;
         // mostly rewind into written data so pops return real bits
         if (sel < 81) op.position = PositionW'($urandom_range(0, shadow_wr_pos));
      end else if (sel < 92) begin
         op.opcode = OP_SET_WRITE;
      end else if (sel < 93) begin
         op.opcode = OP_CLEAR;
      end else begin
         op.opcode = OpcodeW'($urandom_range(OpFirstUnused, OpLastUnused));
      end
      return op;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch %0d at %0t: %s", error_count, $realtime, msg);
   endtask

   task automatic check_result();
      bit_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("response transfer with nothing outstanding");
         return;
      end
      want = pending_results.pop_front();
      result_count++;
      if (want.status == STAT_NO_ROOM) no_room_count++;
      if (want.status == STAT_PAST_WRITE) past_write_count++;
      if (rsp_bus.read_data !== want.read_data)
         report_mismatch($sformatf("read_data got %h want %h",
                                   rsp_bus.read_data, want.read_data));
      if (rsp_bus.status !== want.status)
         report_mismatch($sformatf("status got %0d want %0d (%s)",
                                   rsp_bus.status, want.status, want.status.name()));
      if (rsp_bus.read_position !== want.read_position)
         report_mismatch($sformatf("read_position got %0d want %0d",
                                   rsp_bus.read_position, want.read_position));
      if (rsp_bus.write_position !== want.write_position)
         report_mismatch($sformatf("write_position got %0d want %0d",
                                   rsp_bus.write_position, want.write_position));
   endtask

   // response sink with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            check_result();
            rsp_hold = rsp_idle_on ? $urandom_range(0, 7) : 0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_bus.ready <= (rsp_hold == 0);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("timeout: no transfer for %0d cycles", IdleLimit);
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_op(input bit_op_type op);
      int             gap;
      bit_result_type expected;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         if (req_valid_high) begin
            req_bus.valid <= 1'b0;
            req_valid_high = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= op.opcode;
      req_bus.width    <= op.width;
      req_bus.data     <= op.data;
      req_bus.position <= op.position;
      req_valid_high = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      op_count[op.opcode]++;
      expected = predict_bit_buffer(op);
      pending_results = {pending_results, expected};
   endtask

   // hold off requests until every outstanding response has arrived
   task automatic wait_for_results();
      if (req_valid_high) begin
         req_bus.valid <= 1'b0;
         req_valid_high = 1'b0;
      end
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic program_capacity(input logic [CapW-1:0] value);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_cap_bytes = value;
      cap_settings++;
   endtask

   task automatic test_basic_ops();
      send_op(make_op(OP_PUSH, 6'd0, '1, '0));
      send_op(make_op(OP_PUSH, 6'd32, '1, '0));
      send_op(make_op(OP_PUSH, 6'd63, 32'ha5a5_a5a5, '0));
      send_op(make_op(OP_PUSH, 6'd7, 32'h0000_005a, '0));
      send_op(make_op(OP_POP, 6'd0, '0, '0));
      send_op(make_op(OP_POP, 6'd63, '0, '0));
      send_op(make_op(OP_POP, 6'd32, '0, '0));
      send_op(make_op(OP_POP, 6'd16, '0, '0));
      send_op(make_op(OpFirstUnused, '1, '1, '1));
      send_op(make_op(OpLastUnused, 6'd5, 32'h1234_5678, 16'h0100));
      send_op(make_op(OP_SET_READ, '0, '0, '1));
      send_op(make_op(OP_SET_WRITE, '0, '0, 16'h7fff));
      send_op(make_op(OP_PUSH, 6'd32, '1, '0));
      send_op(make_op(OP_PUSH, 6'd1, 32'h1, '0));
      send_op(make_op(OP_POP, 6'd32, '0, '0));
      send_op(make_op(OP_CLEAR, '1, '1, '1));
      send_op(make_op(OP_POP, 6'd8, '0, '0));
   endtask

   task automatic test_capacity_limits();
      // zero clamps to one byte
      program_capacity('0);
      send_op(make_op(OP_PUSH, 6'd8, 32'h0000_00ff, '0));
      send_op(make_op(OP_PUSH, 6'd1, '1, '0));
      send_op(make_op(OP_POP, 6'd12, '0, '0));
      program_capacity('1);
      send_op(make_op(OP_SET_WRITE, '0, '0, '1));
      // shrink to the read pointer and under the write pointer
      program_capacity(13'd1);
      send_op(make_op(OP_PUSH, 6'd0, '0, '0));
      send_op(make_op(OP_SET_READ, '0, '0, 16'd10));
   endtask

   task automatic test_random_traffic();
      logic [CapW-1:0] cap_value;
      int              counted;
      for (int ph = 0; ph < NumPhases; ph++) begin
         case (ph)
            0:       cap_value = 13'd2;
            1:       cap_value = CapW'($urandom_range(1, 64));
            2:       cap_value = '0;
            3:       cap_value = '1;
            4:       cap_value = CapW'($urandom());
            5:       cap_value = CapReset;
            default: cap_value = CapW'($urandom_range(1, 32));
         endcase
         program_capacity(cap_value);
         // one phase in three runs flat out on both sides
         req_idle_on = (ph % 3 != 1);
         rsp_idle_on = (ph % 3 != 1);
         counted = 0;
         while (counted < 85) begin
            bit_op_type op;
            op = random_op();
            send_op(op);
            if (op.opcode < OpFirstUnused) counted++;
            if ($urandom_range(0, 49) == 0) wait_for_results();
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.opcode   = OP_PUSH;
      req_bus.width    = '0;
      req_bus.data     = '0;
      req_bus.position = '0;
      rsp_bus.ready    = 1'b0;
      req_valid_high   = 1'b0;
      req_idle_on      = 1'b1;
      rsp_idle_on      = 1'b1;
      error_count      = 0;
      result_count     = 0;
      unused_count     = 0;
      no_room_count    = 0;
      past_write_count = 0;
      cap_settings     = 0;
      idle_cycles      = 0;
      rsp_hold         = 0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (shadow_store[i]) shadow_store[i] = '0;
      shadow_rd_pos    = 0;
      shadow_wr_pos    = 0;
      shadow_cap_bytes = CapReset;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_capacity_limits();
      test_random_traffic();

      wait_for_results();
      repeat (SettleTicks) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));

      for (int c = int'(OpFirstUnused); c <= int'(OpLastUnused); c++)
         unused_count += op_count[c];
      $display("covered %0d push, %0d pop, %0d clear, %0d set, %0d unused-code transfers",
               op_count[OP_PUSH], op_count[OP_POP], op_count[OP_CLEAR],
               op_count[OP_SET_READ] + op_count[OP_SET_WRITE], unused_count);
      $display("%0d responses checked over %0d capacity settings: %0d no-room, %0d past-write",
               result_count, cap_settings, no_room_count, past_write_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
